@@ hw/rtl/mrac_pkg.sv @@
`timescale 1ns / 1ps

package mrac_pkg;

  localparam int DataW  = 32;
  localparam int CoefW  = 31;
  localparam int CfgIdxW = 4;

  // digit-serial multiplier: DataW-bit operand consumed MulDigitW bits per cycle
  localparam int MulDigitW = 4;
  localparam int MulSteps  = DataW / MulDigitW;
  localparam int ProdW     = 2 * DataW;

  localparam int SqrtSteps = ProdW / 2;
  localparam int DivSteps  = DataW - 1;

  localparam logic [CoefW-1:0] ModelPoleReset     = 31'd966367641;
  localparam logic [DataW-1:0] ModelInputGainReset = 32'd107374182;
  localparam logic [CoefW-1:0] GainNormLimitReset = 31'd268435456;
  localparam logic [DataW-1:0] DriveMinReset      = 32'h8000_0000;
  localparam logic [DataW-1:0] DriveMaxReset      = 32'h7fff_ffff;
  // reset b_m rescaled from Q2.30 to Q8.24, rounded
  localparam logic [DataW-1:0] GainRefReset       = 32'd1677722;

  localparam logic CmdSample  = 1'b0;
  localparam logic CmdRestart = 1'b1;

  typedef enum logic [CfgIdxW-1:0] {
    CfgModelPole      = 4'd0,
    CfgModelInputGain = 4'd1,
    CfgStepGainRef    = 4'd2,
    CfgStepGainOut    = 4'd3,
    CfgLeakRate       = 4'd4,
    CfgGainNormLimit  = 4'd5,
    CfgDriveMin       = 4'd6,
    CfgDriveMax       = 4'd7
  } cfg_idx_e;

  typedef enum logic [3:0] {
    OpGrR,
    OpGoY,
    OpER,
    OpEY,
    OpSrEr,
    OpLkGr,
    OpSoEy,
    OpLkGo,
    OpGrSq,
    OpGoSq,
    OpLimSq,
    OpGrLim,
    OpGoLim,
    OpAmYm,
    OpBmR
  } op_e;

  typedef enum logic [6:0] {
    StIdle  = 7'b0000001,
    StMul   = 7'b0000010,
    StRound = 7'b0000100,
    StClamp = 7'b0001000,
    StSqrt  = 7'b0010000,
    StDiv   = 7'b0100000,
    StOut   = 7'b1000000
  } state_e;

  typedef struct packed {
    logic [DataW-1:0] drive;
    logic             drive_clamped;
    logic             gains_projected;
    logic [DataW-1:0] model_error;
  } result_t;

  function automatic logic [63:0] sat64(input logic [64:0] x);
    logic [63:0] r;
    if (x[64] != x[63]) begin
      r = x[64] ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
    end else begin
      r = x[63:0];
    end
    return r;
  endfunction

  function automatic logic [31:0] sat32(input logic [63:0] x);
    logic [31:0] r;
    if (x[63] && !(&x[62:31])) begin
      r = 32'h8000_0000;
    end else if (!x[63] && (|x[62:31])) begin
      r = 32'h7fff_ffff;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  // round half up, then arithmetic shift right by n
  function automatic logic signed [63:0] rshr64(input logic [63:0] x, input int unsigned n);
    logic [64:0]        half;
    logic signed [63:0] h;
    half = 65'd1 << (n - 1);
    h = sat64({x[63], x} + half);
    return h >>> n;
  endfunction

endpackage

@@ hw/rtl/mrac_if.sv @@
`timescale 1ns / 1ps

interface mrac_sample_if;
  logic                           valid;
  logic                           ready;
  logic                           cmd;
  logic [mrac_pkg::DataW-1:0]     plant_output;
  logic [mrac_pkg::DataW-1:0]     reference;
  logic [mrac_pkg::DataW-1:0]     init_gain_ref;
  logic [mrac_pkg::DataW-1:0]     init_gain_out;

  modport source (output valid, cmd, plant_output, reference, init_gain_ref, init_gain_out,
                  input ready);
  modport sink (input valid, cmd, plant_output, reference, init_gain_ref, init_gain_out,
                output ready);
endinterface

interface mrac_result_if;
  logic                       valid;
  logic                       ready;
  logic [mrac_pkg::DataW-1:0] drive;
  logic                       drive_clamped;
  logic                       gains_projected;
  logic [mrac_pkg::DataW-1:0] model_error;

  modport source (output valid, drive, drive_clamped, gains_projected, model_error,
                  input ready);
  modport sink (input valid, drive, drive_clamped, gains_projected, model_error,
                output ready);
endinterface

interface mrac_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [mrac_pkg::CfgIdxW-1:0] index;
  logic [mrac_pkg::DataW-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ hw/rtl/mrac_mul.sv @@
`timescale 1ns / 1ps

module mrac_mul (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic signed [mrac_pkg::DataW-1:0]  a_i,
  input  logic signed [mrac_pkg::DataW-1:0]  b_i,
  output logic                               done_o,
  output logic signed [mrac_pkg::ProdW-1:0]  prod_o
);

  localparam int W     = mrac_pkg::DataW;
  localparam int D     = mrac_pkg::MulDigitW;
  localparam int PW    = mrac_pkg::ProdW;
  localparam int StepW = $clog2(mrac_pkg::MulSteps + 1);

  logic [PW-1:0]    p_q;
  logic [W-1:0]     a_q;
  logic             neg_q, busy_q, done_q;
  logic [StepW-1:0] cnt_q;

  logic [W-1:0]     a_mag, b_mag;
  logic [W+D-1:0]   pp, acc;
  logic [PW-1:0]    p_step;

  assign a_mag = a_i[W-1] ? W'(-a_i) : a_i;
  assign b_mag = b_i[W-1] ? W'(-b_i) : b_i;

  // add one digit's partial product to the high half, shift right a digit
  always_comb begin
    pp     = {{D{1'b0}}, a_q} * {{W{1'b0}}, p_q[D-1:0]};
    acc    = {{D{1'b0}}, p_q[PW-1:W]} + pp;
    p_step = {acc, p_q[W-1:D]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_q    <= '0;
      a_q    <= '0;
      neg_q  <= 1'b0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      a_q    <= a_mag;
      p_q    <= {{W{1'b0}}, b_mag};
      neg_q  <= a_i[W-1] ^ b_i[W-1];
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      if (cnt_q == StepW'(mrac_pkg::MulSteps)) begin
        p_q    <= neg_q ? PW'(-p_q) : p_q;
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        p_q   <= p_step;
        cnt_q <= cnt_q + StepW'(1);
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  assign done_o = done_q;
  assign prod_o = p_q;

endmodule

@@ hw/rtl/mrac_sqrt.sv @@
`timescale 1ns / 1ps

module mrac_sqrt (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [mrac_pkg::ProdW-1:0]   value_i,
  output logic                         done_o,
  output logic [mrac_pkg::DataW-1:0]   root_o
);

  localparam int PW    = mrac_pkg::ProdW;
  localparam int W     = mrac_pkg::DataW;
  localparam int RemW  = W + 2;
  localparam int StepW = $clog2(mrac_pkg::SqrtSteps + 1);

  logic [PW-1:0]    v_q;
  logic [RemW-1:0]  rem_q;
  logic [W-1:0]     root_q;
  logic             busy_q, done_q;
  logic [StepW-1:0] cnt_q;

  logic [RemW+1:0]  rem2, trial;
  logic             ge;

  // bring down two bits, try the next root bit
  always_comb begin
    rem2  = {rem_q, v_q[PW-1:PW-2]};
    trial = {2'b00, root_q, 2'b01};
    ge    = rem2 >= trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q    <= '0;
      rem_q  <= '0;
      root_q <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      v_q    <= value_i;
      rem_q  <= '0;
      root_q <= '0;
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      v_q    <= {v_q[PW-3:0], 2'b00};
      rem_q  <= ge ? RemW'(rem2 - trial) : RemW'(rem2);
      root_q <= {root_q[W-2:0], ge};
      if (cnt_q == StepW'(mrac_pkg::SqrtSteps - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        cnt_q <= cnt_q + StepW'(1);
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

@@ hw/rtl/mrac_div.sv @@
`timescale 1ns / 1ps

// Quotient of a signed product by a positive divisor, truncated toward zero.
// The quotient magnitude is known to fit DataW-1 bits.
module mrac_div (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic signed [mrac_pkg::ProdW-1:0]  dividend_i,
  input  logic [mrac_pkg::DataW-1:0]         divisor_i,
  output logic                               done_o,
  output logic signed [mrac_pkg::DataW-1:0]  quot_o
);

  localparam int PW    = mrac_pkg::ProdW;
  localparam int W     = mrac_pkg::DataW;
  localparam int QW    = mrac_pkg::DivSteps;
  localparam int StepW = $clog2(mrac_pkg::DivSteps + 2);

  logic [W-1:0]     rem_q, div_q;
  logic [QW-1:0]    dq_q;
  logic [W-1:0]     quot_q;
  logic             neg_q, busy_q, done_q;
  logic [StepW-1:0] cnt_q;

  logic [PW-1:0]    mag;
  logic [W:0]       rem2;
  logic             ge;

  assign mag = dividend_i[PW-1] ? PW'(-dividend_i) : dividend_i;

  always_comb begin
    rem2 = {rem_q, dq_q[QW-1]};
    ge   = rem2 >= {1'b0, div_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      div_q  <= '0;
      dq_q   <= '0;
      quot_q <= '0;
      neg_q  <= 1'b0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      rem_q  <= mag[PW-2:QW];
      dq_q   <= mag[QW-1:0];
      div_q  <= divisor_i;
      neg_q  <= dividend_i[PW-1];
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      if (cnt_q == StepW'(QW)) begin
        quot_q <= neg_q ? W'(-{1'b0, dq_q}) : {1'b0, dq_q};
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        rem_q <= ge ? W'(rem2 - {1'b0, div_q}) : rem2[W-1:0];
        dq_q  <= {dq_q[QW-2:0], ge};
        cnt_q <= cnt_q + StepW'(1);
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

@@ hw/rtl/mrac_adaptive_controller_core.sv @@
// Sample beat: up to fifteen passes through the shared 4-bit-digit multiplier;
// when the gains are projected, also the 2-bit-per-cycle square root and two
// 1-bit-per-cycle divisions. Restart beat: no arithmetic, straight to output.
// One beat in work at a time.
// Reset (asynchronous, active low) loads the register defaults, gain_ref = b_m
// in Q8.24, gain_out = 0 and model output = 0.
`timescale 1ns / 1ps

module mrac_adaptive_controller_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  mrac_sample_if.sink   sample_i,
  mrac_cfg_if.sink      cfg_i,
  mrac_result_if.source result_o
);

  localparam int W = mrac_pkg::DataW;
  localparam int C = mrac_pkg::CoefW;

  // configuration
  logic [C-1:0] pole_q, step_r_q, step_o_q, leak_q, lim_q;
  logic [W-1:0] bm_q, dmin_q, dmax_q;

  // state and work registers
  logic signed [W-1:0]  gr_q, gr_d, go_q, go_d, ym_q, ym_d;
  logic signed [W-1:0]  y_q, y_d, r_q, r_d, e_q, e_d, er_q, er_d, ey_q, ey_d;
  logic signed [63:0]   prod1_q, prod1_d;
  logic [64:0]          s65_q, s65_d;
  logic signed [39:0]   u40_q, u40_d;
  logic [43:0]          acc_q, acc_d;
  logic [63:0]          sumsq_q, sumsq_d;
  logic [W-1:0]         drive_q, drive_d;
  logic                 clamp_q, clamp_d, proj_q, proj_d;
  mrac_pkg::result_t    res_q, res_d;
  logic                 out_valid_q, out_valid_d;
  mrac_pkg::op_e        op_q, op_d;
  mrac_pkg::state_e     state_q, state_d;
  logic                 mul_start_q, mul_start_d, sqrt_start_q, sqrt_start_d;
  logic                 div_start_q, div_start_d;

  logic signed [W-1:0]  mul_a, mul_b;
  logic signed [63:0]   mul_p;
  logic                 mul_done, sqrt_done, div_done;
  logic [W-1:0]         root;
  logic signed [W-1:0]  quot;

  logic signed [63:0]   rnd;
  logic [43:0]          t44;
  logic signed [39:0]   dmin40, dmax40, v1;
  logic [W-1:0]         bm_gain;
  logic                 in_acc;

  mrac_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start_q),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_p)
  );

  mrac_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start_q),
    .value_i (sumsq_q),
    .done_o  (sqrt_done),
    .root_o  (root)
  );

  mrac_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start_q),
    .dividend_i (mul_p),
    .divisor_i  (root),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  assign cfg_i.ready    = 1'b1;
  assign sample_i.ready = (state_q == mrac_pkg::StIdle);
  assign in_acc         = sample_i.valid && sample_i.ready;

  assign result_o.valid           = out_valid_q;
  assign result_o.drive           = res_q.drive;
  assign result_o.drive_clamped   = res_q.drive_clamped;
  assign result_o.gains_projected = res_q.gains_projected;
  assign result_o.model_error     = res_q.model_error;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pole_q   <= mrac_pkg::ModelPoleReset;
      bm_q     <= mrac_pkg::ModelInputGainReset;
      step_r_q <= '0;
      step_o_q <= '0;
      leak_q   <= '0;
      lim_q    <= mrac_pkg::GainNormLimitReset;
      dmin_q   <= mrac_pkg::DriveMinReset;
      dmax_q   <= mrac_pkg::DriveMaxReset;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        mrac_pkg::CfgModelPole:      pole_q   <= cfg_i.data[C-1:0];
        mrac_pkg::CfgModelInputGain: bm_q     <= cfg_i.data;
        mrac_pkg::CfgStepGainRef:    step_r_q <= cfg_i.data[C-1:0];
        mrac_pkg::CfgStepGainOut:    step_o_q <= cfg_i.data[C-1:0];
        mrac_pkg::CfgLeakRate:       leak_q   <= cfg_i.data[C-1:0];
        mrac_pkg::CfgGainNormLimit:  lim_q    <= cfg_i.data[C-1:0];
        mrac_pkg::CfgDriveMin:       dmin_q   <= cfg_i.data;
        mrac_pkg::CfgDriveMax:       dmax_q   <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // multiplier operands for each step of the sample sequence
  always_comb begin
    case (op_q)
      mrac_pkg::OpGrR:   begin mul_a = gr_q;               mul_b = r_q;  end
      mrac_pkg::OpGoY:   begin mul_a = go_q;               mul_b = y_q;  end
      mrac_pkg::OpER:    begin mul_a = e_q;                mul_b = r_q;  end
      mrac_pkg::OpEY:    begin mul_a = e_q;                mul_b = y_q;  end
      mrac_pkg::OpSrEr:  begin mul_a = {1'b0, step_r_q};   mul_b = er_q; end
      mrac_pkg::OpLkGr:  begin mul_a = {1'b0, leak_q};     mul_b = gr_q; end
      mrac_pkg::OpSoEy:  begin mul_a = {1'b0, step_o_q};   mul_b = ey_q; end
      mrac_pkg::OpLkGo:  begin mul_a = {1'b0, leak_q};     mul_b = go_q; end
      mrac_pkg::OpGrSq:  begin mul_a = gr_q;               mul_b = gr_q; end
      mrac_pkg::OpGoSq:  begin mul_a = go_q;               mul_b = go_q; end
      mrac_pkg::OpLimSq: begin mul_a = {1'b0, lim_q};      mul_b = {1'b0, lim_q}; end
      mrac_pkg::OpGrLim: begin mul_a = gr_q;               mul_b = {1'b0, lim_q}; end
      mrac_pkg::OpGoLim: begin mul_a = go_q;               mul_b = {1'b0, lim_q}; end
      mrac_pkg::OpAmYm:  begin mul_a = {pole_q[C-1], pole_q}; mul_b = ym_q; end
      mrac_pkg::OpBmR:   begin mul_a = bm_q;               mul_b = r_q;  end
      default:           begin mul_a = '0;                 mul_b = '0;   end
    endcase
  end

  always_comb begin
    gr_d         = gr_q;
    go_d         = go_q;
    ym_d         = ym_q;
    y_d          = y_q;
    r_d          = r_q;
    e_d          = e_q;
    er_d         = er_q;
    ey_d         = ey_q;
    prod1_d      = prod1_q;
    s65_d        = s65_q;
    u40_d        = u40_q;
    acc_d        = acc_q;
    sumsq_d      = sumsq_q;
    drive_d      = drive_q;
    clamp_d      = clamp_q;
    proj_d       = proj_q;
    res_d        = res_q;
    op_d         = op_q;
    state_d      = state_q;
    mul_start_d  = 1'b0;
    sqrt_start_d = 1'b0;
    div_start_d  = 1'b0;
    out_valid_d  = out_valid_q && !result_o.ready;

    bm_gain = W'(mrac_pkg::rshr64({{32{bm_q[W-1]}}, bm_q}, 6));
    dmin40  = {{8{dmin_q[W-1]}}, dmin_q};
    dmax40  = {{8{dmax_q[W-1]}}, dmax_q};
    v1      = (u40_q < dmin40) ? dmin40 : u40_q;
    rnd     = '0;
    t44     = '0;

    case (state_q)
      mrac_pkg::StIdle: begin
        if (in_acc) begin
          if (sample_i.cmd == mrac_pkg::CmdRestart) begin
            gr_d    = (sample_i.init_gain_ref != '0) ? sample_i.init_gain_ref : bm_gain;
            go_d    = sample_i.init_gain_out;
            ym_d    = '0;
            drive_d = '0;
            clamp_d = 1'b0;
            proj_d  = 1'b0;
            e_d     = '0;
            state_d = mrac_pkg::StOut;
          end else begin
            y_d         = sample_i.plant_output;
            r_d         = sample_i.reference;
            e_d         = mrac_pkg::sat32(
                {{32{sample_i.plant_output[W-1]}}, sample_i.plant_output}
                - {{32{ym_q[W-1]}}, ym_q});
            proj_d      = 1'b0;
            op_d        = mrac_pkg::OpGrR;
            state_d     = mrac_pkg::StMul;
            mul_start_d = 1'b1;
          end
        end
      end

      mrac_pkg::StMul: begin
        if (mul_done) begin
          mul_start_d = 1'b1;
          case (op_q)
            mrac_pkg::OpGrR: begin
              prod1_d = mul_p;
              op_d    = mrac_pkg::OpGoY;
            end
            mrac_pkg::OpGoY: begin
              s65_d       = {prod1_q[63], prod1_q} + {mul_p[63], mul_p};
              mul_start_d = 1'b0;
              state_d     = mrac_pkg::StRound;
            end
            mrac_pkg::OpER: begin
              er_d = mrac_pkg::sat32(mrac_pkg::rshr64(mul_p, 16));
              op_d = mrac_pkg::OpEY;
            end
            mrac_pkg::OpEY: begin
              ey_d = mrac_pkg::sat32(mrac_pkg::rshr64(mul_p, 16));
              op_d = mrac_pkg::OpSrEr;
            end
            mrac_pkg::OpSrEr: begin
              rnd   = mrac_pkg::rshr64(mul_p, 22);
              acc_d = {{12{gr_q[W-1]}}, gr_q} - rnd[43:0];
              op_d  = mrac_pkg::OpLkGr;
            end
            mrac_pkg::OpLkGr: begin
              rnd  = mrac_pkg::rshr64(mul_p, 30);
              t44  = acc_q - rnd[43:0];
              gr_d = mrac_pkg::sat32({{20{t44[43]}}, t44});
              op_d = mrac_pkg::OpSoEy;
            end
            mrac_pkg::OpSoEy: begin
              rnd   = mrac_pkg::rshr64(mul_p, 22);
              acc_d = {{12{go_q[W-1]}}, go_q} - rnd[43:0];
              op_d  = mrac_pkg::OpLkGo;
            end
            mrac_pkg::OpLkGo: begin
              rnd  = mrac_pkg::rshr64(mul_p, 30);
              t44  = acc_q - rnd[43:0];
              go_d = mrac_pkg::sat32({{20{t44[43]}}, t44});
              op_d = mrac_pkg::OpGrSq;
            end
            mrac_pkg::OpGrSq: begin
              sumsq_d = mul_p;
              op_d    = mrac_pkg::OpGoSq;
            end
            mrac_pkg::OpGoSq: begin
              sumsq_d = sumsq_q + mul_p;
              op_d    = mrac_pkg::OpLimSq;
            end
            mrac_pkg::OpLimSq: begin
              if (sumsq_q > mul_p) begin
                proj_d       = 1'b1;
                mul_start_d  = 1'b0;
                sqrt_start_d = 1'b1;
                state_d      = mrac_pkg::StSqrt;
              end else begin
                op_d = mrac_pkg::OpAmYm;
              end
            end
            mrac_pkg::OpGrLim, mrac_pkg::OpGoLim: begin
              mul_start_d = 1'b0;
              div_start_d = 1'b1;
              state_d     = mrac_pkg::StDiv;
            end
            mrac_pkg::OpAmYm: begin
              prod1_d = mul_p;
              op_d    = mrac_pkg::OpBmR;
            end
            mrac_pkg::OpBmR: begin
              ym_d        = mrac_pkg::sat32(mrac_pkg::rshr64(prod1_q + mul_p, 30));
              mul_start_d = 1'b0;
              state_d     = mrac_pkg::StOut;
            end
            default: begin
              mul_start_d = 1'b0;
              state_d     = mrac_pkg::StIdle;
            end
          endcase
        end
      end

      mrac_pkg::StRound: begin
        rnd     = mrac_pkg::rshr64(mrac_pkg::sat64(s65_q), 24);
        u40_d   = rnd[39:0];
        state_d = mrac_pkg::StClamp;
      end

      mrac_pkg::StClamp: begin
        // lower bound first, upper bound wins on inverted bounds
        drive_d     = (v1 > dmax40) ? dmax_q : v1[W-1:0];
        clamp_d     = (u40_q < dmin40) || (v1 > dmax40);
        op_d        = mrac_pkg::OpER;
        state_d     = mrac_pkg::StMul;
        mul_start_d = 1'b1;
      end

      mrac_pkg::StSqrt: begin
        if (sqrt_done) begin
          op_d        = mrac_pkg::OpGrLim;
          state_d     = mrac_pkg::StMul;
          mul_start_d = 1'b1;
        end
      end

      mrac_pkg::StDiv: begin
        if (div_done) begin
          if (op_q == mrac_pkg::OpGrLim) begin
            gr_d = quot;
            op_d = mrac_pkg::OpGoLim;
          end else begin
            go_d = quot;
            op_d = mrac_pkg::OpAmYm;
          end
          state_d     = mrac_pkg::StMul;
          mul_start_d = 1'b1;
        end
      end

      mrac_pkg::StOut: begin
        // hold until the output register is free
        if (!out_valid_q || result_o.ready) begin
          res_d.drive           = drive_q;
          res_d.drive_clamped   = clamp_q;
          res_d.gains_projected = proj_q;
          res_d.model_error     = e_q;
          out_valid_d           = 1'b1;
          state_d               = mrac_pkg::StIdle;
        end
      end

      default: state_d = mrac_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gr_q         <= mrac_pkg::GainRefReset;
      go_q         <= '0;
      ym_q         <= '0;
      state_q      <= mrac_pkg::StIdle;
      op_q         <= mrac_pkg::OpGrR;
      mul_start_q  <= 1'b0;
      sqrt_start_q <= 1'b0;
      div_start_q  <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      gr_q         <= gr_d;
      go_q         <= go_d;
      ym_q         <= ym_d;
      state_q      <= state_d;
      op_q         <= op_d;
      mul_start_q  <= mul_start_d;
      sqrt_start_q <= sqrt_start_d;
      div_start_q  <= div_start_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    y_q     <= y_d;
    r_q     <= r_d;
    e_q     <= e_d;
    er_q    <= er_d;
    ey_q    <= ey_d;
    prod1_q <= prod1_d;
    s65_q   <= s65_d;
    u40_q   <= u40_d;
    acc_q   <= acc_d;
    sumsq_q <= sumsq_d;
    drive_q <= drive_d;
    clamp_q <= clamp_d;
    proj_q  <= proj_d;
    res_q   <= res_d;
  end

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import mrac_pkg::*;

  localparam logic [CfgIdxW-1:0] CfgIdxUnused = 4'd12;
  localparam int WatchdogLimit = 20000;
  localparam int HoldOffCycles = 3000;
  localparam longint Int32Max = 64'sd2147483647;
  localparam longint Int32Min = -64'sd2147483648;

  // Bit-accurate controller predictor plus the queue of pending results
  class mrac_scoreboard;
    longint pole, bm, step_ref, step_out, leak, norm_lim, dmin, dmax;
    longint gain_r, gain_y, ym;
    result_t expected_q[$];
    int errors;

    function new();
      pole = 966367641;
      bm = 107374182;
      step_ref = 0;
      step_out = 0;
      leak = 0;
      norm_lim = 268435456;
      dmin = Int32Min;
      dmax = Int32Max;
      gain_r = rnd_shift(bm, 6);
      gain_y = 0;
      ym = 0;
      errors = 0;
    endfunction

    function longint sat_add(longint a, longint b);
      logic [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) return s[64] ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
      return longint'(s[63:0]);
    endfunction

    // round half up, then floor shift
    function longint rnd_shift(longint x, int n);
      longint h;
      h = sat_add(x, 64'sd1 <<< (n - 1));
      return h >>> n;
    endfunction

    function longint clip32(longint x);
      if (x > Int32Max) return Int32Max;
      if (x < Int32Min) return Int32Min;
      return x;
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (v >= res + bitv) begin
          v = v - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return res;
    endfunction

    function longint unsigned square_mag(longint g);
      longint unsigned a;
      a = (g < 0) ? longint'(-g) : g;
      return a * a;
    endfunction

    function longint adapt_gain(longint g, longint stepv, longint corr);
      longint d1, d2;
      d1 = rnd_shift(stepv * corr, 22);
      d2 = rnd_shift(leak * g, 30);
      return clip32(g - d1 - d2);
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [DataW-1:0] d);
      logic signed [30:0] c31;
      logic signed [31:0] c32;
      c31 = d[30:0];
      c32 = d;
      case (idx)
        CfgModelPole:      pole = c31;
        CfgModelInputGain: bm = c32;
        CfgStepGainRef:    step_ref = d[30:0];
        CfgStepGainOut:    step_out = d[30:0];
        CfgLeakRate:       leak = d[30:0];
        CfgGainNormLimit:  norm_lim = d[30:0];
        CfgDriveMin:       dmin = c32;
        CfgDriveMax:       dmax = c32;
        default: ;
      endcase
    endfunction

    function void note_sample(logic cmd, logic signed [31:0] y_in, logic signed [31:0] r_in,
                              logic signed [31:0] g0_in, logic signed [31:0] g1_in);
      longint y, r, e, u, er, ey, n;
      longint unsigned sumsq, lim2;
      result_t res;
      y = y_in;
      r = r_in;
      res = '0;
      if (cmd == CmdRestart) begin
        gain_r = (g0_in != 0) ? longint'(g0_in) : rnd_shift(bm, 6);
        gain_y = g1_in;
        ym = 0;
        expected_q.push_back(res);
        return;
      end
      e = clip32(y - ym);
      u = rnd_shift(sat_add(gain_r * r, gain_y * y), 24);
      if (u < dmin) begin
        u = dmin;
        res.drive_clamped = 1'b1;
      end
      if (u > dmax) begin
        u = dmax;
        res.drive_clamped = 1'b1;
      end
      er = clip32(rnd_shift(e * r, 16));
      ey = clip32(rnd_shift(e * y, 16));
      gain_r = adapt_gain(gain_r, step_ref, er);
      gain_y = adapt_gain(gain_y, step_out, ey);
      sumsq = square_mag(gain_r) + square_mag(gain_y);
      lim2 = norm_lim * norm_lim;
      if (sumsq > lim2) begin
        n = int_sqrt(sumsq);
        gain_r = (gain_r * norm_lim) / n;
        gain_y = (gain_y * norm_lim) / n;
        res.gains_projected = 1'b1;
      end
      ym = clip32(rnd_shift(pole * ym + bm * r, 30));
      res.drive = u[31:0];
      res.model_error = e[31:0];
      expected_q.push_back(res);
    endfunction

    task report(string what, longint got, longint exp);
      $display("mismatch %s: got %0d expected %0d", what, got, exp);
      errors++;
    endtask

    task check(result_t got);
      result_t exp;
      if (expected_q.size() == 0) begin
        report("unexpected result beat", got.drive, 0);
        return;
      end
      exp = expected_q.pop_front();
      if (got.drive !== exp.drive) report("drive", got.drive, exp.drive);
      if (got.drive_clamped !== exp.drive_clamped)
        report("drive_clamped", got.drive_clamped, exp.drive_clamped);
      if (got.gains_projected !== exp.gains_projected)
        report("gains_projected", got.gains_projected, exp.gains_projected);
      if (got.model_error !== exp.model_error)
        report("model_error", got.model_error, exp.model_error);
    endtask
  endclass

  logic clk;
  logic rst_n;
  int send_idle_pct;
  int recv_stall_pct;
  int holdoff_left;
  int quiet_cycles;
  mrac_scoreboard sb;

  mrac_sample_if sample_bus ();
  mrac_cfg_if    cfg_bus ();
  mrac_result_if result_bus ();

  mrac_adaptive_controller_core i_dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .sample_i(sample_bus),
    .cfg_i   (cfg_bus),
    .result_o(result_bus)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    forever begin
      @(negedge clk);
      if (holdoff_left > 0) begin
        holdoff_left--;
        result_bus.ready <= 1'b0;
      end else begin
        result_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (result_bus.valid && result_bus.ready) begin
      sb.check('{result_bus.drive, result_bus.drive_clamped, result_bus.gains_projected,
                 result_bus.model_error});
    end
  end

  always @(posedge clk) begin
    if ((sample_bus.valid && sample_bus.ready) || (result_bus.valid && result_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready) || !rst_n) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [DataW-1:0] d);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= d;
    do @(posedge clk); while (!cfg_bus.ready);
    sb.set_reg(idx, d);
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
    @(negedge clk);
  endtask

  // valid stays high between back-to-back beats unless a gap is drawn
  task automatic send_item(logic cmd, logic [31:0] y, logic [31:0] r,
                           logic [31:0] g0, logic [31:0] g1);
    if ($urandom_range(99) < send_idle_pct) begin
      sample_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    sample_bus.valid         <= 1'b1;
    sample_bus.cmd           <= cmd;
    sample_bus.plant_output  <= y;
    sample_bus.reference     <= r;
    sample_bus.init_gain_ref <= g0;
    sample_bus.init_gain_out <= g1;
    do @(posedge clk); while (!sample_bus.ready);
    sb.note_sample(cmd, y, r, g0, g1);
    @(negedge clk);
  endtask

  task automatic drain();
    sample_bus.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_extreme();
    case ($urandom_range(4))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return 32'h0000_0001;
    endcase
  endfunction

  function automatic logic [31:0] pick_signal();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(9))
      0, 1, 2, 3: return {{14{v[31]}}, v[17:0]};
      4, 5, 6:    return {{8{v[31]}}, v[23:0]};
      7:          return pick_extreme();
      default:    return v;
    endcase
  endfunction

  function automatic logic [31:0] pick_gain();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(5))
      0:       return 32'h0;
      1, 2:    return {{7{v[31]}}, v[24:0]};
      3:       return pick_extreme();
      default: return v;
    endcase
  endfunction

  function automatic logic [31:0] pick_rate();
    return $urandom >> $urandom_range(1, 31);
  endfunction

  task automatic load_regs(logic [31:0] pole, logic [31:0] bm, logic [31:0] sr,
                           logic [31:0] so, logic [31:0] lk, logic [31:0] lim,
                           logic [31:0] lo, logic [31:0] hi);
    write_reg(CfgModelPole, pole);
    write_reg(CfgModelInputGain, bm);
    write_reg(CfgStepGainRef, sr);
    write_reg(CfgStepGainOut, so);
    write_reg(CfgLeakRate, lk);
    write_reg(CfgGainNormLimit, lim);
    write_reg(CfgDriveMin, lo);
    write_reg(CfgDriveMax, hi);
  endtask

  task automatic run_random(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 6) send_item(CmdRestart, $urandom, $urandom, pick_gain(), pick_gain());
      else send_item(CmdSample, pick_signal(), pick_signal(), $urandom, $urandom);
    end
  endtask

  initial begin
    sb = new();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    holdoff_left = 0;
    quiet_cycles = 0;
    rst_n = 1'b0;
    sample_bus.valid = 1'b0;
    sample_bus.cmd = CmdSample;
    sample_bus.plant_output = '0;
    sample_bus.reference = '0;
    sample_bus.init_gain_ref = '0;
    sample_bus.init_gain_out = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = CfgModelPole;
    cfg_bus.data = '0;
    result_bus.ready = 1'b0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: reset gains, signal extremes, restart corners
    send_item(CmdSample, 32'h0001_0000, 32'h0001_0000, '0, '0);
    send_item(CmdSample, 32'h7fff_ffff, 32'h7fff_ffff, '0, '0);
    send_item(CmdSample, 32'h8000_0000, 32'h8000_0000, '0, '0);
    send_item(CmdSample, 32'h7fff_ffff, 32'h8000_0000, '0, '0);
    send_item(CmdSample, 32'h0, 32'h0, '0, '0);
    send_item(CmdRestart, 32'hffff_ffff, 32'hffff_ffff, 32'h0, 32'h0);
    send_item(CmdSample, 32'hffff_ffff, 32'h0000_0001, '0, '0);
    send_item(CmdRestart, '0, '0, 32'h7fff_ffff, 32'h8000_0000);
    send_item(CmdSample, 32'h7fff_ffff, 32'h7fff_ffff, '0, '0);
    send_item(CmdRestart, '0, '0, 32'h8000_0000, 32'h7fff_ffff);
    send_item(CmdSample, 32'h8000_0000, 32'h0001_0000, '0, '0);
    send_item(CmdRestart, '0, '0, 32'h0000_0001, 32'hffff_ffff);
    send_item(CmdSample, 32'h0003_0000, 32'hfffd_0000, '0, '0);
    drain();

    // adaptation active, tight clamp and inverted clamp, zero norm limit
    load_regs(32'd966367641, 32'd107374182, 32'h0010_0000, 32'h0010_0000, 32'h400,
              32'd268435456, 32'hfff0_0000, 32'h0010_0000);
    write_reg(CfgIdxUnused, 32'hdead_beef);
    send_item(CmdRestart, '0, '0, 32'h0100_0000, 32'h0080_0000);
    send_item(CmdSample, 32'h0020_0000, 32'h0040_0000, '0, '0);
    send_item(CmdSample, 32'hffe0_0000, 32'h7fff_ffff, '0, '0);
    send_item(CmdSample, 32'h8000_0000, 32'h0040_0000, '0, '0);
    drain();
    write_reg(CfgGainNormLimit, 32'h0);
    write_reg(CfgDriveMin, 32'h0001_0000);
    write_reg(CfgDriveMax, 32'hffff_0000);
    send_item(CmdSample, 32'h0001_0000, 32'h0002_0000, '0, '0);
    send_item(CmdRestart, '0, '0, 32'h0, 32'h0);
    send_item(CmdSample, 32'h0, 32'h0, '0, '0);
    drain();

    // extremes of every register
    load_regs(32'd1073741823, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
              32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    send_idle_pct = 63;
    run_random(150);
    drain();

    load_regs(32'hc000_0001, 32'h8000_0000, 32'h0, 32'h0, 32'h0, 32'h1,
              32'hffff_0000, 32'h0001_0000);
    send_idle_pct = 0;
    recv_stall_pct = 63;
    run_random(150);
    drain();

    load_regs(32'd966367641, 32'd107374182, 32'h0004_0000, 32'h0002_0000, 32'h100,
              32'd268435456, 32'hff00_0000, 32'h0100_0000);
    send_idle_pct = 13;
    recv_stall_pct = 13;
    run_random(150);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      load_regs($urandom, $urandom, pick_rate(), pick_rate(), pick_rate(),
                $urandom_range(1, 32'h7fff_ffff) >> $urandom_range(0, 8),
                {1'b1, 31'($urandom)}, {1'b0, 31'($urandom)});
      case (ph)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 13;
          recv_stall_pct = 13;
          holdoff_left = HoldOffCycles;
        end
        2: begin
          send_idle_pct = 63;
          recv_stall_pct = 0;
        end
        default: begin
          send_idle_pct = 0;
          recv_stall_pct = 63;
        end
      endcase
      run_random(160);
      drain();
    end

    repeat (20) @(negedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
